### src/smc_pkg.sv
`default_nettype none

package smc_pkg;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 40;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [7:0] IDX_CR1     = 8'd0;
  localparam logic [7:0] IDX_CR2     = 8'd1;
  localparam logic [7:0] IDX_SR      = 8'd2;
  localparam logic [7:0] IDX_DR      = 8'd3;
  localparam logic [7:0] IDX_CRCPR   = 8'd4;
  localparam logic [7:0] IDX_RXCRCR  = 8'd5;
  localparam logic [7:0] IDX_TXCRCR  = 8'd6;
  localparam logic [7:0] IDX_I2SCFGR = 8'd7;
  localparam logic [7:0] IDX_I2SPR   = 8'd8;

  localparam int CR1_SPE = 6;
  localparam int CR1_SSI = 8;
  localparam int CR1_SSM = 9;
  localparam int CR1_DFF = 11;

  localparam logic [31:0] CRCPR_VALUE = 32'h0000_0007;
  localparam logic [31:0] I2SPR_VALUE = 32'h0000_0002;

  localparam logic [4:0] WORD_BITS_8  = 5'd8;
  localparam logic [4:0] WORD_BITS_16 = 5'd16;

  typedef enum logic [1:0] {
    KIND_READ,
    KIND_WRITE,
    KIND_TICK,
    KIND_NONE
  } kind_t;

  typedef enum logic [2:0] {
    SEL_CR1,
    SEL_CR2,
    SEL_SR,
    SEL_DR,
    SEL_CRCPR,
    SEL_I2SPR,
    SEL_NONE
  } sel_t;

  typedef struct packed {
    kind_t       kind;
    sel_t        sel;
    logic [15:0] wdata;
    logic        miso;
  } cmd_t;

  typedef struct packed {
    logic       busy;
    logic       txe;
    logic       pend;
    logic [4:0] bits_left;
  } status_t;

endpackage

`default_nettype wire

### src/spi_master_controller.sv
// Channel  Dir  tuser           tdata (low bit up)
// s_*      in   operation[1:0]  reg_index[7:0] write_data[31:0] miso_bit, zero pad
// m_*      out  -               read_data[31:0] sck_level mosi_level cs_level, pad
//
// One transfer in and one out per clock when both sides flow.
// The decoded item is registered in the queue; then the execute stage updates
// registers, shifters and pins and loads the output register.
// The queue of QUEUE_DEPTH entries absorbs output stalls; s_tready drops when full.
// Synchronous reset clears all control state (queue entries and m_tdata are not reset); no clearing pass.
`default_nettype none

module spi_master_controller import smc_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // operation
  input  wire logic [IN_USER_W-1:0]  s_tuser,
  // reg_index, write_data, miso_bit
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // read_data, sck_level, mosi_level, cs_level
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  cmd_t    in_cmd;
  cmd_t    q_cmd;
  logic    q_valid;
  logic    q_ready;
  status_t status;

  smc_front u_front (
    .tuser (s_tuser),
    .tdata (s_tdata),
    .cmd   (in_cmd)
  );

  smc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s_tvalid),
    .push_ready (s_tready),
    .push_cmd   (in_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  smc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .status    (status)
  );

`ifndef NO_ASSERTIONS
  a_busy_bits: assert property (@(posedge clk) disable iff (rst)
    status.busy == (status.bits_left != 5'd0))
    else $error("busy flag disagrees with bit count");

  a_txe_pend: assert property (@(posedge clk) disable iff (rst)
    status.txe == !status.pend)
    else $error("tx empty flag disagrees with pending buffer");

  a_pend_busy: assert property (@(posedge clk) disable iff (rst)
    status.pend |-> status.busy)
    else $error("pending word while idle");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(status))
    else $error("state advanced during output stall");
`endif

endmodule

`default_nettype wire

### src/smc_front.sv
`default_nettype none

module smc_front import smc_pkg::*; (
  input  wire logic [IN_USER_W-1:0] tuser,
  input  wire logic [IN_DATA_W-1:0] tdata,
  output cmd_t                      cmd
);

  logic [7:0] reg_index;

  assign reg_index = tdata[7:0];

  always_comb begin
    cmd.wdata = tdata[23:8];
    cmd.miso  = tdata[40];

    unique case (tuser)
      OP_READ:  cmd.kind = KIND_READ;
      OP_WRITE: cmd.kind = KIND_WRITE;
      OP_TICK:  cmd.kind = KIND_TICK;
      default:  cmd.kind = KIND_NONE;
    endcase

    // indices 5..7 and unknown ones read zero and ignore writes
    unique case (reg_index)
      IDX_CR1:   cmd.sel = SEL_CR1;
      IDX_CR2:   cmd.sel = SEL_CR2;
      IDX_SR:    cmd.sel = SEL_SR;
      IDX_DR:    cmd.sel = SEL_DR;
      IDX_CRCPR: cmd.sel = SEL_CRCPR;
      IDX_I2SPR: cmd.sel = SEL_I2SPR;
      default:   cmd.sel = SEL_NONE;
    endcase
  end

endmodule

`default_nettype wire

### src/smc_queue.sv
`default_nettype none

module smc_queue import smc_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire cmd_t push_cmd,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_cmd
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/smc_back.sv
`default_nettype none

module smc_back import smc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  input  wire cmd_t                  cmd,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output status_t                    status
);

  logic [15:0] cr1, cr1_next;
  logic [7:0]  cr2, cr2_next;
  logic        rxne, rxne_next;
  logic        txe, txe_next;
  logic        busy, busy_next;
  logic [15:0] rx_word, rx_word_next;
  logic [15:0] shift_out, shift_out_next;
  logic [15:0] pend_word, pend_word_next;
  logic        pend, pend_next;
  logic [4:0]  bits_left, bits_left_next;
  logic [15:0] shift_in, shift_in_next;
  logic        sck, sck_next;
  logic        mosi, mosi_next;
  logic        cs, cs_next;
  logic [31:0] rd;
  logic [4:0]  word_bits;
  logic [3:0]  pos;
  logic [15:0] sampled;
  logic        do_exec;

  assign cmd_ready = !m_tvalid || m_tready;
  assign do_exec   = cmd_valid && cmd_ready;
  assign word_bits = cr1[CR1_DFF] ? WORD_BITS_16 : WORD_BITS_8;
  assign pos       = 4'(bits_left - 5'd1);

  always_comb begin
    sampled      = shift_in;
    sampled[pos] = shift_in[pos] | cmd.miso;
  end

  always_comb begin
    cr1_next       = cr1;
    cr2_next       = cr2;
    rxne_next      = rxne;
    txe_next       = txe;
    busy_next      = busy;
    rx_word_next   = rx_word;
    shift_out_next = shift_out;
    pend_word_next = pend_word;
    pend_next      = pend;
    bits_left_next = bits_left;
    shift_in_next  = shift_in;
    sck_next       = sck;
    mosi_next      = mosi;
    cs_next        = cs;
    rd             = '0;

    unique case (cmd.kind)
      KIND_READ: begin
        unique case (cmd.sel)
          SEL_CR1:   rd = {16'd0, cr1};
          SEL_CR2:   rd = {24'd0, cr2};
          SEL_SR:    rd = {24'd0, busy, 5'd0, txe, rxne};
          SEL_DR: begin
            rd        = {16'd0, rx_word};
            rxne_next = 1'b0;
          end
          SEL_CRCPR: rd = CRCPR_VALUE;
          SEL_I2SPR: rd = I2SPR_VALUE;
          default:   rd = '0;
        endcase
      end
      KIND_WRITE: begin
        unique case (cmd.sel)
          SEL_CR1: begin
            cr1_next = cmd.wdata;
            if (cr1[CR1_SPE] && !cmd.wdata[CR1_SPE]) begin
              shift_out_next = '0;
              shift_in_next  = '0;
              pend_word_next = '0;
              pend_next      = 1'b0;
              bits_left_next = '0;
              busy_next      = 1'b0;
              txe_next       = 1'b1;
            end else if (cmd.wdata[CR1_SPE] && cmd.wdata[CR1_SSM]) begin
              cs_next = cmd.wdata[CR1_SSI];
            end
          end
          SEL_CR2: cr2_next = cmd.wdata[7:0];
          SEL_DR: begin
            if (cr1[CR1_SPE] && txe) begin
              if (!busy) begin
                busy_next      = 1'b1;
                shift_out_next = cmd.wdata;
                bits_left_next = word_bits;
              end else begin
                txe_next       = 1'b0;
                pend_word_next = cmd.wdata;
                pend_next      = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      KIND_TICK: begin
        if (busy && bits_left != '0) begin
          if (sck) begin
            shift_in_next  = sampled;
            bits_left_next = bits_left - 5'd1;
            if (bits_left == 5'd1) begin
              if (pend) begin
                pend_next      = 1'b0;
                shift_out_next = pend_word;
                bits_left_next = word_bits;
                txe_next       = 1'b1;
              end else begin
                busy_next = 1'b0;
              end
              rx_word_next  = sampled;
              shift_in_next = '0;
              rxne_next     = 1'b1;
            end
          end else begin
            mosi_next = shift_out[pos];
          end
          sck_next = !sck;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cr1       <= '0;
      cr2       <= '0;
      rxne      <= 1'b0;
      txe       <= 1'b1;
      busy      <= 1'b0;
      rx_word   <= '0;
      shift_out <= '0;
      pend_word <= '0;
      pend      <= 1'b0;
      bits_left <= '0;
      shift_in  <= '0;
      sck       <= 1'b0;
      mosi      <= 1'b1;
      cs        <= 1'b1;
      m_tvalid  <= 1'b0;
    end else begin
      if (do_exec) begin
        cr1       <= cr1_next;
        cr2       <= cr2_next;
        rxne      <= rxne_next;
        txe       <= txe_next;
        busy      <= busy_next;
        rx_word   <= rx_word_next;
        shift_out <= shift_out_next;
        pend_word <= pend_word_next;
        pend      <= pend_next;
        bits_left <= bits_left_next;
        shift_in  <= shift_in_next;
        sck       <= sck_next;
        mosi      <= mosi_next;
        cs        <= cs_next;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_exec) begin
      m_tdata <= {5'd0, cs_next, mosi_next, sck_next, rd};
    end
  end

  assign status.busy      = busy;
  assign status.txe       = txe;
  assign status.pend      = pend;
  assign status.bits_left = bits_left;

endmodule

`default_nettype wire
